FILE: hdl/assert_macros.svh
// Assertion macros shared by the clipper modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked at each rising edge outside reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked at each rising edge outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: hdl/wmlc_pkg.sv
// Types, codes and constants of the window map line clipper
package wmlc_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int MAX_PASSES_DEF = 8;

    // outcode bits
    localparam logic [3:0] OC_LEFT   = 4'h1;
    localparam logic [3:0] OC_TOP    = 4'h2;
    localparam logic [3:0] OC_RIGHT  = 4'h4;
    localparam logic [3:0] OC_BOTTOM = 4'h8;
    localparam logic [3:0] OC_ALL    = 4'hF;

    // register indexes
    localparam logic [2:0] REG_VP_LEFT    = 3'd0;
    localparam logic [2:0] REG_VP_TOP     = 3'd1;
    localparam logic [2:0] REG_VP_RIGHT   = 3'd2;
    localparam logic [2:0] REG_VP_BOTTOM  = 3'd3;
    localparam logic [2:0] REG_WIN_LEFT   = 3'd4;
    localparam logic [2:0] REG_WIN_TOP    = 3'd5;
    localparam logic [2:0] REG_WIN_WIDTH  = 3'd6;
    localparam logic [2:0] REG_WIN_HEIGHT = 3'd7;

    localparam int CFG_DATA_W = 17;

    // endpoint selects for the mapping step
    localparam logic [1:0] SEL_X1 = 2'd0;
    localparam logic [1:0] SEL_Y1 = 2'd1;
    localparam logic [1:0] SEL_X2 = 2'd2;
    localparam logic [1:0] SEL_Y2 = 2'd3;

    typedef struct packed {
        logic [11:0]        vp_left;
        logic [11:0]        vp_top;
        logic [11:0]        vp_right;
        logic [11:0]        vp_bottom;
        logic signed [15:0] win_left;
        logic signed [15:0] win_top;
        logic signed [16:0] win_width;
        logic signed [16:0] win_height;
    } cfg_t;

    typedef enum logic [1:0] {
        EDGE_LEFT,
        EDGE_RIGHT,
        EDGE_TOP,
        EDGE_BOTTOM
    } edge_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV,
        MD_FIN
    } md_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP_GO,
        ST_MAP_WAIT,
        ST_TEST,
        ST_EDGE,
        ST_CLIP_WAIT,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic       load_in;
        logic       map_start;
        logic       map_wr;
        logic [1:0] map_sel;
        logic       swap;
        logic       snap;
        logic       clip_start;
        logic       clip_wr;
        logic       out_load;
        logic       out_vis;
    } dp_cmd_t;

    typedef struct packed {
        logic md_done;
        logic both_in;
        logic share;
        logic c1_in;
        logic vertical;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: hdl/window_map_line_clipper.sv
// Window-to-viewport line mapper and clipper, top level
// Input channel (in_valid/in_ready) takes one word: a segment given by
// start_x/start_y/end_x/end_y in world coordinates. Output channel
// (out_valid/out_ready) returns one word per segment: visible and the
// clipped device endpoints, all zero when not visible.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data);
// write it only while no segment is in flight.
// Each segment runs four mapping operations and up to MAX_PASSES clip
// passes, each clip pass one operation or a vertical snap. Every
// operation runs on one shared multiply-divide unit of width
// W = max(COORD_BITS,16)+16. A clip pass also goes through a test
// state and an edge-select state. Segments are processed one at a
// time.
// Reset empties the output register, idles the controller and loads the
// default viewport and window. A stalled receiver holds the result word;
// the next segment is accepted and processed, then waits before hand-off.
module window_map_line_clipper #(
    parameter int COORD_BITS = wmlc_pkg::COORD_BITS_DEF,
    parameter int MAX_PASSES = wmlc_pkg::MAX_PASSES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [2:0]                    cfg_index,
    input  logic [wmlc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  start_x,
    input  logic signed [COORD_BITS-1:0]  start_y,
    input  logic signed [COORD_BITS-1:0]  end_x,
    input  logic signed [COORD_BITS-1:0]  end_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          visible,
    output logic [11:0]                   clip_x1,
    output logic [11:0]                   clip_y1,
    output logic [11:0]                   clip_x2,
    output logic [11:0]                   clip_y2
);
    import wmlc_pkg::*;

    cfg_t     cfg_reg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vp_left    <= 12'd0;
            cfg_reg.vp_top     <= 12'd0;
            cfg_reg.vp_right   <= 12'd79;
            cfg_reg.vp_bottom  <= 12'd24;
            cfg_reg.win_left   <= 16'sd0;
            cfg_reg.win_top    <= 16'sd0;
            cfg_reg.win_width  <= 17'sd79;
            cfg_reg.win_height <= 17'sd24;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_VP_LEFT:    cfg_reg.vp_left    <= cfg_data[11:0];
                REG_VP_TOP:     cfg_reg.vp_top     <= cfg_data[11:0];
                REG_VP_RIGHT:   cfg_reg.vp_right   <= cfg_data[11:0];
                REG_VP_BOTTOM:  cfg_reg.vp_bottom  <= cfg_data[11:0];
                REG_WIN_LEFT:   cfg_reg.win_left   <= signed'(cfg_data[15:0]);
                REG_WIN_TOP:    cfg_reg.win_top    <= signed'(cfg_data[15:0]);
                REG_WIN_WIDTH:  cfg_reg.win_width  <= signed'(cfg_data[16:0]);
                REG_WIN_HEIGHT: cfg_reg.win_height <= signed'(cfg_data[16:0]);
                default:        cfg_reg.vp_left    <= cfg_reg.vp_left;
            endcase
        end
    end

    wmlc_ctrl #(
        .MAX_PASSES (MAX_PASSES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wmlc_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .stat      (stat),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .visible   (visible),
        .clip_x1   (clip_x1),
        .clip_y1   (clip_y1),
        .clip_x2   (clip_x2),
        .clip_y2   (clip_y2)
    );

endmodule

FILE: hdl/wmlc_muldiv.sv
// Iterative exact signed multiply-then-divide unit, truncating toward zero
`include "assert_macros.svh"
module wmlc_muldiv #(
    parameter int D_W = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [D_W-1:0] a,
    input  logic signed [D_W-1:0] b,
    input  logic signed [D_W-1:0] c,
    output logic                  done,
    output logic signed [D_W-1:0] q
);
    import wmlc_pkg::*;

    localparam int P_W   = 2 * D_W;
    localparam int CNT_W = $clog2(P_W);

    md_phase_t          phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [P_W-1:0]     acc_reg;
    logic [P_W-1:0]     mcand_reg;
    logic [D_W-1:0]     mplier_reg;
    logic [D_W-1:0]     div_reg;
    logic [D_W-1:0]     rem_reg;
    logic [D_W-1:0]     quo_reg;
    logic               neg_reg;

    logic [D_W-1:0]     ma, mb, mc;
    logic [D_W:0]       trial;
    logic               fit;
    logic               mul_last, div_last;

    // operand magnitudes
    assign ma = a[D_W-1] ? (~a + 1'b1) : a;
    assign mb = b[D_W-1] ? (~b + 1'b1) : b;
    assign mc = c[D_W-1] ? (~c + 1'b1) : c;

    assign trial    = {rem_reg, acc_reg[P_W-1]};
    assign fit      = (trial >= {1'b0, div_reg});
    assign mul_last = (cnt_reg == CNT_W'(D_W - 1));
    assign div_last = (cnt_reg == CNT_W'(P_W - 1));

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            MD_IDLE: if (start) phase_next = MD_MUL;
            MD_MUL:  if (mul_last) phase_next = MD_DIV;
            MD_DIV:  if (div_last) phase_next = MD_FIN;
            MD_FIN:  phase_next = MD_IDLE;
            default: phase_next = MD_IDLE;
        endcase
    end

    // result outputs
    always_comb
    begin
        done = (phase_reg == MD_FIN);
        if (div_reg == '0)
            q = '0;
        else if (neg_reg)
            q = signed'(~quo_reg + 1'b1);
        else
            q = signed'(quo_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MD_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (phase_reg != phase_next)
                cnt_reg <= '0;
            else if (phase_reg == MD_MUL || phase_reg == MD_DIV)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // shift-add product, then restoring division one bit a cycle
    always_ff @(posedge clk)
    begin
        unique case (phase_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    acc_reg    <= '0;
                    mcand_reg  <= P_W'(ma);
                    mplier_reg <= mb;
                    div_reg    <= mc;
                    rem_reg    <= '0;
                    quo_reg    <= '0;
                    neg_reg    <= (a[D_W-1] ^ b[D_W-1]) ^ c[D_W-1];
                end
            end
            MD_MUL:
            begin
                if (mplier_reg[0])
                    acc_reg <= acc_reg + mcand_reg;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
            end
            MD_DIV:
            begin
                acc_reg <= acc_reg << 1;
                quo_reg <= {quo_reg[D_W-2:0], fit};
                rem_reg <= fit ? D_W'(trial - {1'b0, div_reg}) : trial[D_W-1:0];
            end
            MD_FIN:
            begin
                acc_reg <= acc_reg;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    `ASSERT_SAME(a_start_idle, clk, rst_n, start, phase_reg == MD_IDLE, "start while unit busy")
    `ASSERT_NEXT(a_start_runs, clk, rst_n, start, phase_reg == MD_MUL, "start did not begin product")
    `ASSERT_SAME(a_done_quiet, clk, rst_n, done, !start, "start during result cycle")

endmodule

FILE: hdl/wmlc_datapath.sv
// Coordinate registers, outcodes, operand selection and result register
module wmlc_datapath #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wmlc_pkg::cfg_t               cfg,
    input  wmlc_pkg::dp_cmd_t            cmd,
    output wmlc_pkg::dp_stat_t           stat,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         visible,
    output logic [11:0]                  clip_x1,
    output logic [11:0]                  clip_y1,
    output logic [11:0]                  clip_x2,
    output logic [11:0]                  clip_y2
);
    import wmlc_pkg::*;

    localparam int A_W = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;
    localparam int V_W = A_W + 14;
    localparam int D_W = V_W + 1;

    logic signed [V_W-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [V_W-1:0] x1_next, y1_next, x2_next, y2_next;
    edge_t                 edge_reg, edge_next, edge_cur;
    logic                  out_valid_reg, visible_reg;
    logic [11:0]           cx1_reg, cy1_reg, cx2_reg, cy2_reg;

    logic signed [V_W-1:0] e_l, e_t, e_r, e_b;
    logic signed [D_W-1:0] wl_d, wt_d, ww_d, wh_d, vdx_d, vdy_d;
    logic signed [D_W-1:0] x1_d, y1_d, x2_d, y2_d;
    logic [11:0]           vdx, vdy;
    logic [3:0]            c1, c2;
    logic signed [D_W-1:0] md_a, md_b, md_c, md_q;
    logic                  md_start, md_done;
    logic signed [V_W-1:0] q_v;

    // viewport edges and window terms at working width
    assign e_l  = signed'({{(V_W-12){1'b0}}, cfg.vp_left});
    assign e_t  = signed'({{(V_W-12){1'b0}}, cfg.vp_top});
    assign e_r  = signed'({{(V_W-12){1'b0}}, cfg.vp_right});
    assign e_b  = signed'({{(V_W-12){1'b0}}, cfg.vp_bottom});
    assign vdx  = (cfg.vp_right >= cfg.vp_left) ? (cfg.vp_right - cfg.vp_left)
                                                : (cfg.vp_left - cfg.vp_right);
    assign vdy  = (cfg.vp_bottom >= cfg.vp_top) ? (cfg.vp_bottom - cfg.vp_top)
                                                : (cfg.vp_top - cfg.vp_bottom);
    assign vdx_d = signed'({{(D_W-12){1'b0}}, vdx});
    assign vdy_d = signed'({{(D_W-12){1'b0}}, vdy});
    assign wl_d = {{(D_W-16){cfg.win_left[15]}}, cfg.win_left};
    assign wt_d = {{(D_W-16){cfg.win_top[15]}}, cfg.win_top};
    assign ww_d = {{(D_W-17){cfg.win_width[16]}}, cfg.win_width};
    assign wh_d = {{(D_W-17){cfg.win_height[16]}}, cfg.win_height};
    assign x1_d = {x1_reg[V_W-1], x1_reg};
    assign y1_d = {y1_reg[V_W-1], y1_reg};
    assign x2_d = {x2_reg[V_W-1], x2_reg};
    assign y2_d = {y2_reg[V_W-1], y2_reg};

    // outcodes of both endpoints
    assign c1 = {y1_reg > e_b, x1_reg > e_r, y1_reg < e_t, x1_reg < e_l};
    assign c2 = {y2_reg > e_b, x2_reg > e_r, y2_reg < e_t, x2_reg < e_l};

    // edge priority: left, right, top, bottom
    always_comb
    begin
        if ((c1 & OC_LEFT) != '0)
            edge_cur = EDGE_LEFT;
        else if ((c1 & OC_RIGHT) != '0)
            edge_cur = EDGE_RIGHT;
        else if ((c1 & OC_TOP) != '0)
            edge_cur = EDGE_TOP;
        else
            edge_cur = EDGE_BOTTOM;
    end

    // operand select for the shared unit
    always_comb
    begin
        md_a = x1_d - wl_d;
        md_b = vdx_d;
        md_c = ww_d;
        if (cmd.clip_start)
        begin
            unique case (edge_cur)
                EDGE_LEFT:   begin md_a = y2_d - y1_d; md_b = {e_l[V_W-1], e_l} - x1_d;
                                   md_c = x2_d - x1_d; end
                EDGE_RIGHT:  begin md_a = y2_d - y1_d; md_b = {e_r[V_W-1], e_r} - x1_d;
                                   md_c = x2_d - x1_d; end
                EDGE_TOP:    begin md_a = x2_d - x1_d; md_b = {e_t[V_W-1], e_t} - y1_d;
                                   md_c = y2_d - y1_d; end
                EDGE_BOTTOM: begin md_a = x2_d - x1_d; md_b = {e_b[V_W-1], e_b} - y1_d;
                                   md_c = y2_d - y1_d; end
                default:     begin md_a = '0; md_b = '0; md_c = '0; end
            endcase
        end
        else
        begin
            unique case (cmd.map_sel)
                SEL_X1:  begin md_a = x1_d - wl_d; md_b = vdx_d; md_c = ww_d; end
                SEL_Y1:  begin md_a = y1_d - wt_d; md_b = vdy_d; md_c = wh_d; end
                SEL_X2:  begin md_a = x2_d - wl_d; md_b = vdx_d; md_c = ww_d; end
                SEL_Y2:  begin md_a = y2_d - wt_d; md_b = vdy_d; md_c = wh_d; end
                default: begin md_a = '0; md_b = '0; md_c = '0; end
            endcase
        end
    end

    assign md_start = cmd.map_start | cmd.clip_start;

    wmlc_muldiv #(
        .D_W (D_W)
    ) u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .a     (md_a),
        .b     (md_b),
        .c     (md_c),
        .done  (md_done),
        .q     (md_q)
    );

    assign q_v = md_q[V_W-1:0];

    // next values of the endpoint registers
    always_comb
    begin
        x1_next   = x1_reg;
        y1_next   = y1_reg;
        x2_next   = x2_reg;
        y2_next   = y2_reg;
        edge_next = edge_reg;
        if (cmd.load_in)
        begin
            x1_next = {{(V_W-COORD_BITS){start_x[COORD_BITS-1]}}, start_x};
            y1_next = {{(V_W-COORD_BITS){start_y[COORD_BITS-1]}}, start_y};
            x2_next = {{(V_W-COORD_BITS){end_x[COORD_BITS-1]}}, end_x};
            y2_next = {{(V_W-COORD_BITS){end_y[COORD_BITS-1]}}, end_y};
        end
        else if (cmd.map_wr)
        begin
            unique case (cmd.map_sel)
                SEL_X1:  x1_next = q_v + e_l;
                SEL_Y1:  y1_next = q_v + e_t;
                SEL_X2:  x2_next = q_v + e_l;
                SEL_Y2:  y2_next = q_v + e_t;
                default: x1_next = x1_reg;
            endcase
        end
        else if (cmd.swap)
        begin
            x1_next = x2_reg;
            y1_next = y2_reg;
            x2_next = x1_reg;
            y2_next = y1_reg;
        end
        else if (cmd.snap)
        begin
            y1_next = ((c1 & OC_TOP) != '0) ? e_t : e_b;
        end
        else if (cmd.clip_wr)
        begin
            unique case (edge_reg)
                EDGE_LEFT:   begin y1_next = y1_reg + q_v; x1_next = e_l; end
                EDGE_RIGHT:  begin y1_next = y1_reg + q_v; x1_next = e_r; end
                EDGE_TOP:    begin x1_next = x1_reg + q_v; y1_next = e_t; end
                EDGE_BOTTOM: begin x1_next = x1_reg + q_v; y1_next = e_b; end
                default:     x1_next = x1_reg;
            endcase
        end
        if (cmd.clip_start)
            edge_next = edge_cur;
    end

    always_ff @(posedge clk)
    begin
        x1_reg   <= x1_next;
        y1_reg   <= y1_next;
        x2_reg   <= x2_next;
        y2_reg   <= y2_next;
        edge_reg <= edge_next;
    end

    // result word: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            visible_reg <= cmd.out_vis;
            cx1_reg     <= cmd.out_vis ? x1_reg[11:0] : 12'd0;
            cy1_reg     <= cmd.out_vis ? y1_reg[11:0] : 12'd0;
            cx2_reg     <= cmd.out_vis ? x2_reg[11:0] : 12'd0;
            cy2_reg     <= cmd.out_vis ? y2_reg[11:0] : 12'd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign visible   = visible_reg;
    assign clip_x1   = cx1_reg;
    assign clip_y1   = cy1_reg;
    assign clip_x2   = cx2_reg;
    assign clip_y2   = cy2_reg;

    // status to the controller
    assign stat.md_done  = md_done;
    assign stat.both_in  = (c1 == '0) && (c2 == '0);
    assign stat.share    = ((c1 & c2 & OC_ALL) != '0);
    assign stat.c1_in    = (c1 == '0);
    assign stat.vertical = (x1_reg == x2_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

endmodule

FILE: hdl/wmlc_ctrl.sv
// Sequencing controller: mapping steps, clip passes and result hand-off
module wmlc_ctrl #(
    parameter int MAX_PASSES = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wmlc_pkg::dp_stat_t stat,
    output wmlc_pkg::dp_cmd_t  cmd
);
    import wmlc_pkg::*;

    localparam int PASS_W = $clog2(MAX_PASSES + 1);

    ctrl_state_t       state_reg, state_next;
    logic [1:0]        sel_reg, sel_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic              vis_reg, vis_next;
    logic              pass_out;

    assign pass_out = (pass_reg == PASS_W'(MAX_PASSES));

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        pass_next  = pass_reg;
        vis_next   = vis_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MAP_GO;
                    sel_next   = SEL_X1;
                    pass_next  = '0;
                end
            end
            ST_MAP_GO:
                state_next = ST_MAP_WAIT;
            ST_MAP_WAIT:
            begin
                if (stat.md_done)
                begin
                    if (sel_reg == SEL_Y2)
                        state_next = ST_TEST;
                    else
                    begin
                        sel_next   = sel_reg + 1'b1;
                        state_next = ST_MAP_GO;
                    end
                end
            end
            ST_TEST:
            begin
                if (pass_out || stat.share)
                begin
                    vis_next   = 1'b0;
                    state_next = ST_FINISH;
                end
                else if (stat.both_in)
                begin
                    vis_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                    state_next = ST_EDGE;
            end
            ST_EDGE:
            begin
                if (stat.vertical)
                begin
                    pass_next  = pass_reg + 1'b1;
                    state_next = ST_TEST;
                end
                else
                    state_next = ST_CLIP_WAIT;
            end
            ST_CLIP_WAIT:
            begin
                if (stat.md_done)
                begin
                    pass_next  = pass_reg + 1'b1;
                    state_next = ST_TEST;
                end
            end
            ST_FINISH:
                if (stat.out_free) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd         = '0;
        cmd.map_sel = sel_reg;
        cmd.out_vis = vis_reg;
        in_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_MAP_GO:    cmd.map_start = 1'b1;
            ST_MAP_WAIT:  cmd.map_wr    = stat.md_done;
            ST_TEST:      cmd.swap      = !pass_out && !stat.share && !stat.both_in
                                          && stat.c1_in;
            ST_EDGE:
            begin
                cmd.snap       = stat.vertical;
                cmd.clip_start = !stat.vertical;
            end
            ST_CLIP_WAIT: cmd.clip_wr   = stat.md_done;
            ST_FINISH:    cmd.out_load  = stat.out_free;
            default:      cmd.load_in   = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= SEL_X1;
            pass_reg  <= '0;
            vis_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            pass_reg  <= pass_next;
            vis_reg   <= vis_next;
        end
    end

endmodule
